/* rtl/x86e_pkg.sv */
// shared types and constants of the x86-64 instruction encoder
package x86e_pkg;

  localparam int unsigned MaxBytes = 15;

  localparam logic [6:0] KindMovRr    = 7'd0;
  localparam logic [6:0] KindMovRi    = 7'd1;
  localparam logic [6:0] KindMovRm    = 7'd2;
  localparam logic [6:0] KindMovMr    = 7'd3;
  localparam logic [6:0] KindMovMi    = 7'd4;
  localparam logic [6:0] KindMovsx    = 7'd5;
  localparam logic [6:0] KindMovzx    = 7'd6;
  localparam logic [6:0] KindMovd     = 7'd7;
  localparam logic [6:0] KindLea      = 7'd8;
  localparam logic [6:0] KindAluRr    = 7'd9;
  localparam logic [6:0] KindAluRi    = 7'd16;
  localparam logic [6:0] KindUnary    = 7'd22;
  localparam logic [6:0] KindShift    = 7'd29;
  localparam logic [6:0] KindCvt      = 7'd35;
  localparam logic [6:0] KindSseMem   = 7'd41;
  localparam logic [6:0] KindSseRr    = 7'd45;
  localparam logic [6:0] KindPush     = 7'd61;
  localparam logic [6:0] KindPop      = 7'd62;
  localparam logic [6:0] KindCallR    = 7'd63;
  localparam logic [6:0] KindCallRel  = 7'd64;
  localparam logic [6:0] KindCallRip  = 7'd65;
  localparam logic [6:0] KindJmp      = 7'd66;
  localparam logic [6:0] KindJcc      = 7'd67;
  localparam logic [6:0] KindSetcc    = 7'd68;
  localparam logic [6:0] KindCwde     = 7'd69;
  localparam logic [6:0] KindCdq      = 7'd70;
  localparam logic [6:0] KindCqo      = 7'd71;
  localparam logic [6:0] KindRet      = 7'd72;
  localparam logic [6:0] KindRdtsc    = 7'd73;
  localparam logic [6:0] KindCpuid    = 7'd74;

  localparam logic [7:0] RexW = 8'h48;
  localparam logic [7:0] RexR = 8'h44;
  localparam logic [7:0] RexX = 8'h42;
  localparam logic [7:0] RexB = 8'h41;
  localparam logic [7:0] PfxOpsz = 8'h66;
  localparam logic [7:0] OpEsc = 8'h0F;

  typedef struct packed {
    logic [6:0]  kind;
    logic [1:0]  op_size;
    logic [1:0]  src_size;
    logic [3:0]  first_reg;
    logic [3:0]  second_reg;
    logic [3:0]  addr_base;
    logic        mem_has_index;
    logic [3:0]  addr_index;
    logic [1:0]  addr_scale;
    logic        mem_rip;
    logic [31:0] displacement;
    logic [63:0] immediate;
  } req_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } rsp_t;

  // encoding skeleton produced by the decode stage
  typedef struct packed {
    logic       pfx_en;
    logic [7:0] pfx;
    logic       rex_en;
    logic [7:0] rex;
    logic [1:0] op_len;
    logic [7:0] op0;
    logic [7:0] op1;
    logic       modrm_en;
    logic [1:0] mode;
    logic [2:0] reg_f;
    logic [2:0] rm_f;
    logic       is_mem;
    logic [2:0] imm_len;
    logic [63:0] imm;
  } enc_t;

  function automatic logic fits8(input logic [63:0] v);
    logic [63:0] t;
    t = v + 64'd128;
    return t < 64'd256;
  endfunction

  function automatic logic [7:0] alu_rr_op(input logic [2:0] i);
    case (i)
      3'd0: return 8'h01;
      3'd1: return 8'h29;
      3'd2: return 8'h21;
      3'd3: return 8'h09;
      3'd4: return 8'h31;
      3'd5: return 8'h39;
      default: return 8'h85;
    endcase
  endfunction

  function automatic logic [2:0] alu_ri_ext(input logic [2:0] i);
    case (i)
      3'd0: return 3'd0;
      3'd1: return 3'd1;
      3'd2: return 3'd4;
      3'd3: return 3'd5;
      3'd4: return 3'd6;
      default: return 3'd7;
    endcase
  endfunction

  function automatic logic [7:0] alu_ri_acc(input logic [2:0] i);
    case (i)
      3'd0: return 8'h04;
      3'd1: return 8'h0C;
      3'd2: return 8'h24;
      3'd3: return 8'h2C;
      3'd4: return 8'h34;
      default: return 8'h3C;
    endcase
  endfunction

  function automatic logic [2:0] una_ext(input logic [2:0] i);
    case (i)
      3'd0: return 3'd4;
      3'd1: return 3'd6;
      3'd2: return 3'd7;
      3'd3: return 3'd3;
      3'd4: return 3'd2;
      3'd5: return 3'd0;
      default: return 3'd1;
    endcase
  endfunction

  function automatic logic [2:0] shf_ext(input logic [2:0] i);
    case (i)
      3'd0, 3'd1: return 3'd4;
      3'd2, 3'd3: return 3'd5;
      default: return 3'd7;
    endcase
  endfunction

  function automatic logic [7:0] cvt_pre(input logic [2:0] i);
    case (i)
      3'd0, 3'd2, 3'd5: return 8'hF3;
      default: return 8'hF2;
    endcase
  endfunction

  function automatic logic [7:0] cvt_op(input logic [2:0] i);
    case (i)
      3'd0, 3'd1: return 8'h2C;
      3'd2, 3'd3: return 8'h2A;
      default: return 8'h5A;
    endcase
  endfunction

  function automatic logic [7:0] sse_pre(input logic [3:0] i);
    case (i)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4: return 8'hF2;
      4'd5, 4'd6, 4'd7: return 8'h66;
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12: return 8'hF3;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] sse_op(input logic [2:0] i);
    case (i)
      3'd0: return 8'h10;
      3'd1: return 8'h58;
      3'd2: return 8'h5C;
      3'd3: return 8'h59;
      3'd4: return 8'h5E;
      3'd5: return 8'h57;
      3'd6: return 8'h2F;
      default: return 8'h2E;
    endcase
  endfunction

endpackage

/* rtl/x86e_stream_if.sv */
// valid/ready channel interface carrying one payload beat
interface x86e_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/x86_64_instruction_encoder.sv */
// top level of the x86-64 instruction encoder
// Usage: req_if (sink) takes one instruction request per beat; code_if
// (source) returns its machine code one byte per beat, with last_byte set
// on the final byte. Unused kinds produce no bytes at all.
// Pipeline: stage 1 registers the request, stage 2 holds the decoded
// encoding skeleton, stage 3 the assembled byte array with its length,
// and a serializer shifts bytes out of a holding register.
// The serializer presents the first byte once the request has passed
// stages 1, 2 and 3. Throughput: one byte per cycle while code_if.ready
// is high; an instruction has n bytes (n = 1 to MAX_LENGTH, typically
// 3 to 5). A zero byte instruction leaves the serializer with no beat.
// Stage 3 refills the holding register in the cycle its last byte is taken.
// Reset: all valid bits clear, no beats are presented.
// Stall: when code_if.ready is low the current byte holds and the
// pipeline fills; req_if.ready falls once every stage is occupied.
module x86_64_instruction_encoder import x86e_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  x86e_stream_if.sink   req_if,
  x86e_stream_if.source code_if
);

  localparam int unsigned LenW = $clog2(MAX_LENGTH + 1);

  // stage 1
  logic s1_v_q;
  req_t s1_q;
  // stage 2
  logic s2_v_q;
  enc_t s2_q;
  logic [1:0] s2_mod_q;
  logic s2_sib_q;
  logic [7:0] s2_sib_byte_q;
  logic [2:0] s2_disp_len_q;
  logic [31:0] s2_disp_q;
  // stage 3
  logic s3_v_q;
  logic [MAX_LENGTH-1:0][7:0] s3_buf_q;
  logic [LenW-1:0] s3_len_q;
  // serializer
  logic so_v_q;
  logic [MAX_LENGTH-1:0][7:0] so_buf_q;
  logic [LenW-1:0] so_len_q;
  logic [LenW-1:0] so_idx_q;

  logic so_done;
  logic so_load;
  logic s3_adv, s2_adv, s1_adv;
  enc_t dec;
  logic [1:0] mod_d;
  logic sib_d;
  logic [7:0] sib_byte_d;
  logic [2:0] disp_len_d;
  logic [MAX_LENGTH-1:0][7:0] buf_d;
  logic [LenW-1:0] len_d;
  logic [7:0] seq [MaxBytes];
  logic [3:0] pos;
  rsp_t rsp;

  x86e_decode u_dec (
    .req_i (s1_q),
    .enc_o (dec)
  );

  assign so_done = so_v_q && ((so_len_q == '0) || (code_if.ready
                   && (so_idx_q == so_len_q - LenW'(1))));
  assign so_load = !so_v_q || so_done;
  assign s3_adv = !s3_v_q || so_load;
  assign s2_adv = !s2_v_q || s3_adv;
  assign s1_adv = !s1_v_q || s2_adv;
  assign req_if.ready = s1_adv;

  // memory operand addressing
  always_comb begin
    sib_d = 1'b0;
    sib_byte_d = 8'h00;
    mod_d = dec.mode;
    disp_len_d = 3'd0;
    if (dec.is_mem) begin
      if (s1_q.mem_rip) begin
        mod_d = 2'd0;
        disp_len_d = 3'd4;
      end else begin
        sib_d = s1_q.mem_has_index || (s1_q.addr_base[2:0] == 3'd4);
        sib_byte_d = s1_q.mem_has_index
                   ? {s1_q.addr_scale, s1_q.addr_index[2:0], s1_q.addr_base[2:0]}
                   : {2'd0, 3'd4, s1_q.addr_base[2:0]};
        if (s1_q.displacement == 32'd0 && s1_q.addr_base[2:0] != 3'd5) begin
          mod_d = 2'd0;
        end else if (fits8({{32{s1_q.displacement[31]}}, s1_q.displacement})) begin
          mod_d = 2'd1;
          disp_len_d = 3'd1;
        end else begin
          mod_d = 2'd2;
          disp_len_d = 3'd4;
        end
      end
    end
  end

  // byte assembly
  always_comb begin
    logic [7:0] rm_byte;
    for (int i = 0; i < MaxBytes; i++) seq[i] = 8'h00;
    rm_byte = {s2_mod_q, s2_q.reg_f, s2_q.rm_f};
    if (s2_q.is_mem) begin
      if (s2_sib_q) rm_byte[2:0] = 3'd4;
      else if (s2_disp_len_q == 3'd4 && s2_mod_q == 2'd0) rm_byte[2:0] = 3'd5;
      else rm_byte[2:0] = s2_q.rm_f;
    end
    pos = 4'd0;
    if (s2_q.pfx_en) begin
      seq[pos] = s2_q.pfx;
      pos = pos + 4'd1;
    end
    if (s2_q.rex_en) begin
      seq[pos] = s2_q.rex;
      pos = pos + 4'd1;
    end
    if (s2_q.op_len != 2'd0) begin
      seq[pos] = s2_q.op0;
      pos = pos + 4'd1;
    end
    if (s2_q.op_len == 2'd2) begin
      seq[pos] = s2_q.op1;
      pos = pos + 4'd1;
    end
    if (s2_q.modrm_en) begin
      seq[pos] = rm_byte;
      pos = pos + 4'd1;
    end
    if (s2_sib_q) begin
      seq[pos] = s2_sib_byte_q;
      pos = pos + 4'd1;
    end
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < s2_disp_len_q) seq[pos + 4'(i)] = s2_disp_q[8*i +: 8];
    end
    pos = pos + {1'b0, s2_disp_len_q};
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < s2_q.imm_len) seq[pos + 4'(i)] = s2_q.imm[8*i +: 8];
    end
    pos = pos + {1'b0, s2_q.imm_len};
    for (int i = 0; i < MAX_LENGTH; i++) buf_d[i] = seq[i];
    len_d = (32'(pos) > MAX_LENGTH) ? LenW'(MAX_LENGTH) : LenW'(pos);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      so_v_q <= 1'b0;
      so_idx_q <= '0;
    end else begin
      if (s1_adv) s1_v_q <= req_if.valid;
      if (s2_adv) s2_v_q <= s1_v_q;
      if (s3_adv) s3_v_q <= s2_v_q;
      if (so_load) begin
        so_v_q <= s3_v_q;
        so_idx_q <= '0;
      end else if (code_if.ready) begin
        so_idx_q <= so_idx_q + LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) s1_q <= req_if.data;
    if (s2_adv) begin
      s2_q <= dec;
      s2_mod_q <= mod_d;
      s2_sib_q <= sib_d;
      s2_sib_byte_q <= sib_byte_d;
      s2_disp_len_q <= disp_len_d;
      s2_disp_q <= s1_q.displacement;
    end
    if (s3_adv) begin
      s3_buf_q <= buf_d;
      s3_len_q <= len_d;
    end
    if (so_load) begin
      so_buf_q <= s3_buf_q;
      so_len_q <= s3_len_q;
    end
  end

  assign rsp.code_byte = so_buf_q[so_idx_q];
  assign rsp.last_byte = (so_idx_q == so_len_q - LenW'(1));
  assign code_if.valid = so_v_q && (so_len_q != '0);
  assign code_if.data = rsp;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_if.valid |-> (so_idx_q < so_len_q))
    else $error("byte index past instruction length");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (code_if.valid && !code_if.ready) |=> $stable(so_idx_q))
    else $error("serializer advanced under stall");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q |-> (s3_len_q <= LenW'(MAX_LENGTH)))
    else $error("instruction length above limit");

endmodule

/* rtl/x86e_decode.sv */
// form decode: request to prefix, rex, opcode, modrm control and immediate
module x86e_decode import x86e_pkg::*; (
  input  req_t req_i,
  output enc_t enc_o
);

  logic [6:0] k;
  logic [1:0] sz;
  logic       w;
  logic       wide;
  logic [3:0] r1;
  logic [3:0] r2;
  logic [7:0] rex_m;
  logic [2:0] sub;
  logic [3:0] sub4;
  logic [2:0] imm_sz;
  logic       f8;

  assign k    = req_i.kind;
  assign sz   = req_i.op_size;
  assign w    = (sz == 2'd3);
  assign wide = (sz != 2'd0);
  assign r1   = req_i.first_reg;
  assign r2   = req_i.second_reg;
  assign f8   = fits8(req_i.immediate);
  assign imm_sz = (sz == 2'd0) ? 3'd1 : (sz == 2'd1) ? 3'd2 : 3'd4;

  always_comb begin
    rex_m = 8'h00;
    if (!req_i.mem_rip) begin
      if (req_i.addr_base[3]) rex_m = rex_m | RexB;
      if (req_i.mem_has_index && req_i.addr_index[3]) rex_m = rex_m | RexX;
    end
  end

  always_comb begin
    enc_o = '0;
    enc_o.imm = req_i.immediate;
    sub  = 3'd0;
    sub4 = 4'd0;
    if (k <= KindMovMi || k == KindLea) begin
      enc_o.pfx_en = (sz == 2'd1) && (k != KindLea);
      enc_o.pfx = PfxOpsz;
      enc_o.op_len = 2'd1;
      if (k == KindMovRr) begin
        enc_o.rex = (w ? RexW : 8'h00) | (r2[3] ? RexR : 8'h00) | (r1[3] ? RexB : 8'h00);
        enc_o.op0 = wide ? 8'h89 : 8'h88;
        enc_o.modrm_en = 1'b1;
        enc_o.mode = 2'd3;
        enc_o.reg_f = r2[2:0];
        enc_o.rm_f = r1[2:0];
      end else if (k == KindMovRi) begin
        enc_o.rex = (w ? RexW : 8'h00) | (r1[3] ? RexB : 8'h00);
        if (sz == 2'd0) begin
          enc_o.op0 = 8'hB0 | {5'd0, r1[2:0]};
          enc_o.imm_len = 3'd1;
        end else if (sz == 2'd2) begin
          enc_o.op0 = 8'hB8 | {5'd0, r1[2:0]};
          enc_o.imm_len = 3'd4;
        end else begin
          enc_o.op0 = 8'hC7;
          enc_o.modrm_en = 1'b1;
          enc_o.mode = 2'd3;
          enc_o.rm_f = r1[2:0];
          enc_o.imm_len = imm_sz;
        end
      end else if (k == KindMovMi) begin
        enc_o.rex = (w ? RexW : 8'h00) | rex_m;
        enc_o.op0 = wide ? 8'hC7 : 8'hC6;
        enc_o.modrm_en = 1'b1;
        enc_o.is_mem = 1'b1;
        enc_o.imm_len = imm_sz;
      end else begin
        enc_o.rex = (w ? RexW : 8'h00) | (r1[3] ? RexR : 8'h00) | rex_m;
        enc_o.op0 = (k == KindLea) ? 8'h8D : (k == KindMovRm) ? (wide ? 8'h8B : 8'h8A)
                  : (wide ? 8'h89 : 8'h88);
        enc_o.modrm_en = 1'b1;
        enc_o.is_mem = 1'b1;
        enc_o.reg_f = r1[2:0];
      end
    end else if (k == KindMovsx || k == KindMovzx || k == KindMovd
                 || (k >= KindCvt && k < KindSseMem) || (k >= KindSseRr && k < KindPush)) begin
      enc_o.rex = ((w && k < KindSseRr) ? RexW : 8'h00) | (r1[3] ? RexR : 8'h00)
                | (r2[3] ? RexB : 8'h00);
      enc_o.modrm_en = 1'b1;
      enc_o.mode = 2'd3;
      enc_o.reg_f = r1[2:0];
      enc_o.rm_f = r2[2:0];
      enc_o.op_len = 2'd2;
      enc_o.op0 = OpEsc;
      enc_o.pfx = PfxOpsz;
      if (k == KindMovsx) begin
        enc_o.pfx_en = (sz == 2'd1) && (req_i.src_size == 2'd0);
        if (req_i.src_size[1]) begin
          enc_o.op_len = 2'd1;
          enc_o.op0 = 8'h63;
        end else begin
          enc_o.op1 = req_i.src_size[0] ? 8'hBF : 8'hBE;
        end
      end else if (k == KindMovzx) begin
        enc_o.pfx_en = (sz == 2'd1);
        enc_o.op1 = (req_i.src_size == 2'd0) ? 8'hB6 : 8'hB7;
      end else if (k == KindMovd) begin
        enc_o.pfx_en = 1'b1;
        enc_o.op1 = 8'h6E;
      end else if (k < KindSseMem) begin
        sub = 3'(k - KindCvt);
        enc_o.pfx_en = 1'b1;
        enc_o.pfx = cvt_pre(sub);
        enc_o.op1 = cvt_op(sub);
      end else begin
        sub4 = 4'(k - KindSseRr);
        enc_o.pfx = sse_pre(sub4);
        enc_o.pfx_en = (enc_o.pfx != 8'h00);
        enc_o.op1 = sse_op(sub4[2:0]);
      end
    end else if (k < KindAluRi) begin
      sub = 3'(k - KindAluRr);
      enc_o.pfx_en = (sz == 2'd1);
      enc_o.pfx = PfxOpsz;
      enc_o.rex = (w ? RexW : 8'h00) | (r2[3] ? RexR : 8'h00) | (r1[3] ? RexB : 8'h00);
      enc_o.op_len = 2'd1;
      enc_o.op0 = wide ? alu_rr_op(sub) : alu_rr_op(sub) - 8'd1;
      enc_o.modrm_en = 1'b1;
      enc_o.mode = 2'd3;
      enc_o.reg_f = r2[2:0];
      enc_o.rm_f = r1[2:0];
    end else if (k < KindSseMem) begin
      enc_o.pfx_en = (sz == 2'd1);
      enc_o.pfx = PfxOpsz;
      enc_o.rex = (w ? RexW : 8'h00) | (r1[3] ? RexB : 8'h00);
      enc_o.op_len = 2'd1;
      enc_o.mode = 2'd3;
      enc_o.rm_f = r1[2:0];
      enc_o.modrm_en = 1'b1;
      if (k < KindUnary) begin
        sub = 3'(k - KindAluRi);
        if (r1 == 4'd0 && (!wide || !f8)) begin
          enc_o.modrm_en = 1'b0;
          enc_o.op0 = alu_ri_acc(sub) + (wide ? 8'd1 : 8'd0);
          enc_o.imm_len = imm_sz;
        end else if (wide && f8) begin
          enc_o.op0 = 8'h83;
          enc_o.reg_f = alu_ri_ext(sub);
          enc_o.imm_len = 3'd1;
        end else begin
          enc_o.op0 = wide ? 8'h81 : 8'h80;
          enc_o.reg_f = alu_ri_ext(sub);
          enc_o.imm_len = imm_sz;
        end
      end else if (k < KindShift) begin
        sub = 3'(k - KindUnary);
        enc_o.op0 = (sub >= 3'd5) ? (wide ? 8'hFF : 8'hFE) : (wide ? 8'hF7 : 8'hF6);
        enc_o.reg_f = una_ext(sub);
      end else begin
        sub = 3'(k - KindShift);
        enc_o.reg_f = shf_ext(sub);
        if (sub[0]) enc_o.op0 = wide ? 8'hD3 : 8'hD2;
        else if (req_i.immediate == 64'd1) enc_o.op0 = wide ? 8'hD1 : 8'hD0;
        else begin
          enc_o.op0 = wide ? 8'hC1 : 8'hC0;
          enc_o.imm_len = 3'd1;
        end
      end
    end else if (k < KindSseRr) begin
      sub = 3'(k - KindSseMem);
      enc_o.pfx_en = 1'b1;
      enc_o.pfx = sub[1] ? 8'hF2 : 8'hF3;
      enc_o.rex = (r1[3] ? RexR : 8'h00) | rex_m;
      enc_o.op_len = 2'd2;
      enc_o.op0 = OpEsc;
      enc_o.op1 = sub[0] ? 8'h10 : 8'h11;
      enc_o.modrm_en = 1'b1;
      enc_o.is_mem = 1'b1;
      enc_o.reg_f = r1[2:0];
    end else begin
      enc_o.imm = {32'd0, req_i.displacement};
      unique case (k)
        KindPush, KindPop: begin
          enc_o.rex = r1[3] ? 8'h49 : 8'h00;
          enc_o.op_len = 2'd1;
          enc_o.op0 = ((k == KindPush) ? 8'h50 : 8'h58) + {5'd0, r1[2:0]};
        end
        KindCallR: begin
          enc_o.rex = r1[3] ? RexB : 8'h00;
          enc_o.op_len = 2'd1;
          enc_o.op0 = 8'hFF;
          enc_o.modrm_en = 1'b1;
          enc_o.mode = 2'd3;
          enc_o.reg_f = 3'd2;
          enc_o.rm_f = r1[2:0];
        end
        KindCallRel, KindJmp: begin
          enc_o.op_len = 2'd1;
          enc_o.op0 = (k == KindJmp) ? 8'hE9 : 8'hE8;
          enc_o.imm_len = 3'd4;
        end
        KindCallRip: begin
          enc_o.op_len = 2'd1;
          enc_o.op0 = 8'hFF;
          enc_o.modrm_en = 1'b1;
          enc_o.reg_f = 3'd2;
          enc_o.rm_f = 3'd5;
          enc_o.imm_len = 3'd4;
        end
        KindJcc: begin
          enc_o.op_len = 2'd2;
          enc_o.op0 = OpEsc;
          enc_o.op1 = 8'h80 + {4'd0, r2};
          enc_o.imm_len = 3'd4;
        end
        KindSetcc: begin
          enc_o.rex = r1[3] ? RexB : 8'h00;
          enc_o.op_len = 2'd2;
          enc_o.op0 = OpEsc;
          enc_o.op1 = 8'h90 | {4'd0, r2};
          enc_o.modrm_en = 1'b1;
          enc_o.mode = 2'd3;
          enc_o.rm_f = r1[2:0];
        end
        KindCwde: begin
          enc_o.op_len = 2'd1;
          enc_o.op0 = 8'h98;
        end
        KindCdq: begin
          enc_o.op_len = 2'd1;
          enc_o.op0 = 8'h99;
        end
        KindCqo: begin
          enc_o.rex = RexW;
          enc_o.op_len = 2'd1;
          enc_o.op0 = 8'h99;
        end
        KindRet: begin
          enc_o.op_len = 2'd1;
          enc_o.op0 = 8'hC3;
        end
        KindRdtsc, KindCpuid: begin
          enc_o.op_len = 2'd2;
          enc_o.op0 = OpEsc;
          enc_o.op1 = (k == KindCpuid) ? 8'hA2 : 8'h31;
        end
        default: enc_o.op_len = 2'd0;
      endcase
    end
    // memory forms place the base register in the rm field
    if (enc_o.is_mem) enc_o.rm_f = req_i.addr_base[2:0];
    enc_o.rex_en = (enc_o.rex != 8'h00);
  end

endmodule
